// ===== src/lwd_pkg.sv =====
// Shared types and constants for the LZSS window decoder.
package lwd_pkg;

    // Default geometry of the history window and the length field
    localparam int WINDOW_BITS_DEF = 13;
    localparam int LENGTH_BITS_DEF = 3;

    // Queue depths between the parts of the decoder
    localparam int CMDQ_DEPTH = 4;
    localparam int OUTQ_DEPTH = 4;

    // Control bits carried by one flag byte, shortest copy run
    localparam logic [3:0] CTRL_BITS = 4'd8;
    localparam int         MIN_MATCH = 3;

    // Input word: one compressed byte
    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_last;
    } t_in;

    // Output word: one decompressed byte
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } t_out;

    // Parser phase of the front end
    typedef enum logic [1:0] {
        PH_FLAG  = 2'd0,
        PH_TOKEN = 2'd1,
        PH_HIGH  = 2'd2
    } t_phase;

    // Command kinds passed from front to back
    typedef enum logic [1:0] {
        CMD_NOP  = 2'd0,
        CMD_LIT  = 2'd1,
        CMD_COPY = 2'd2
    } t_cmd_kind;

    // One command: literal byte in the low half, or the raw 16-bit reference
    typedef struct packed {
        t_cmd_kind   kind;
        logic [15:0] ref_word;
        logic        last;
    } t_cmd;

    // Back end sequencer states
    typedef enum logic [1:0] {
        BS_CLEAR = 2'd0,
        BS_IDLE  = 2'd1,
        BS_COPY  = 2'd2
    } t_bstate;

endpackage

// ===== src/lwd_fifo.sv =====
// Small synchronous queue used between the decoder parts and at the output.
module lwd_fifo #(
    parameter type t_item = logic,
    parameter int  DEPTH  = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  t_item                      i_item,
    output logic                       o_full,
    input  logic                       i_pop,
    output t_item                      o_item,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item           r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers and occupancy, wrapping at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== src/lwd_front.sv =====
// Front end: parses flag, literal and reference bytes into commands.
module lwd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  lwd_pkg::t_in  i_data,
    output logic          o_cmd_valid,
    output lwd_pkg::t_cmd o_cmd
);
    import lwd_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_ctrl, n_ctrl;
    logic [3:0] r_bits, n_bits;
    logic [7:0] r_ref_low, n_ref_low;

    // Classify the accepted word and update the parser state
    always_comb begin
        n_phase     = r_phase;
        n_ctrl      = r_ctrl;
        n_bits      = r_bits;
        n_ref_low   = r_ref_low;
        o_cmd_valid = 1'b0;
        o_cmd.kind     = CMD_NOP;
        o_cmd.ref_word = {8'h00, i_data.in_byte};
        o_cmd.last     = i_data.stream_last;
        if (i_accept) begin
            unique case (r_phase)
                PH_TOKEN: begin
                    if (r_ctrl[0]) begin
                        o_cmd_valid = 1'b1;
                        o_cmd.kind  = CMD_LIT;
                        n_ctrl      = r_ctrl >> 1;
                        n_bits      = (r_bits != 4'd0) ? r_bits - 4'd1 : 4'd0;
                        n_phase     = (n_bits == 4'd0) ? PH_FLAG : PH_TOKEN;
                    end else begin
                        n_ref_low = i_data.in_byte;
                        n_phase   = PH_HIGH;
                    end
                end
                PH_HIGH: begin
                    o_cmd_valid    = 1'b1;
                    o_cmd.kind     = CMD_COPY;
                    o_cmd.ref_word = {i_data.in_byte, r_ref_low};
                    n_ctrl         = r_ctrl >> 1;
                    n_bits         = (r_bits != 4'd0) ? r_bits - 4'd1 : 4'd0;
                    n_phase        = (n_bits == 4'd0) ? PH_FLAG : PH_TOKEN;
                end
                default: begin
                    n_ctrl  = i_data.in_byte;
                    n_bits  = CTRL_BITS;
                    n_phase = PH_TOKEN;
                end
            endcase
            // End of stream: restart the parser, tell the back end to rewind
            if (i_data.stream_last) begin
                o_cmd_valid = 1'b1;
                n_phase     = PH_FLAG;
                n_ctrl      = '0;
                n_bits      = '0;
                n_ref_low   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_FLAG;
            r_ctrl    <= '0;
            r_bits    <= '0;
            r_ref_low <= '0;
        end else begin
            r_phase   <= n_phase;
            r_ctrl    <= n_ctrl;
            r_bits    <= n_bits;
            r_ref_low <= n_ref_low;
        end
    end

endmodule

// ===== src/lwd_back.sv =====
// Back end: clears the window, then runs literal and copy commands.
module lwd_back #(
    parameter int WINDOW_BITS = lwd_pkg::WINDOW_BITS_DEF,
    parameter int LENGTH_BITS = lwd_pkg::LENGTH_BITS_DEF,
    parameter int OUT_DEPTH   = lwd_pkg::OUTQ_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lwd_pkg::t_cmd                  i_cmd,
    input  logic                           i_cmd_empty,
    output logic                           o_cmd_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] i_out_count,
    output logic                           o_out_push,
    output lwd_pkg::t_out                  o_out,
    output logic                           o_clearing
);
    import lwd_pkg::*;

    localparam int WIN_SIZE = 1 << WINDOW_BITS;
    localparam int LEN_W    = LENGTH_BITS + 1;
    localparam int OCW      = $clog2(OUT_DEPTH + 1) + 1;

    // History window
    logic [7:0]             r_win [WIN_SIZE];

    t_bstate                r_state, n_state;
    logic [WINDOW_BITS-1:0] r_clr_cnt;
    logic [WINDOW_BITS-1:0] r_wp;
    logic [WINDOW_BITS-1:0] r_ra, n_ra;
    logic [LEN_W-1:0]       r_left, n_left;
    logic                   r_cp_last, n_cp_last;

    // Write stage registers
    logic                   r_w_valid, n_w_valid;
    logic                   r_w_lit, n_w_lit;
    logic [7:0]             r_w_lit_data, n_w_lit_data;
    logic                   r_w_run_last, n_w_run_last;
    logic                   r_w_clr, n_w_clr;
    logic                   r_fwd, n_fwd;
    logic [7:0]             r_fwd_data;
    logic [7:0]             r_rd_data;

    logic [WINDOW_BITS-1:0] rd_addr;
    logic [WINDOW_BITS-1:0] cmd_pos;
    logic [15:0]            ref_shift;
    logic [LEN_W-1:0]       cmd_len;
    logic                   issue_ok;
    logic [7:0]             w_data;
    logic                   mem_we;
    logic [WINDOW_BITS-1:0] mem_waddr;
    logic [7:0]             mem_wdata;

    // Decode position and run length from the reference
    assign cmd_pos   = i_cmd.ref_word[WINDOW_BITS-1:0];
    assign ref_shift = i_cmd.ref_word >> WINDOW_BITS;
    assign cmd_len   = LEN_W'(ref_shift[LENGTH_BITS-1:0]) + LEN_W'(MIN_MATCH);

    // Issue a byte only if the output queue has room for its push next cycle
    assign issue_ok = (OCW'(i_out_count) + OCW'(r_w_valid)) < OCW'(OUT_DEPTH);

    assign o_clearing = (r_state == BS_CLEAR);

    // Sequence commands; one window read per emitted copy byte
    always_comb begin
        n_state      = r_state;
        n_ra         = r_ra;
        n_left       = r_left;
        n_cp_last    = r_cp_last;
        n_w_valid    = 1'b0;
        n_w_lit      = 1'b0;
        n_w_lit_data = i_cmd.ref_word[7:0];
        n_w_run_last = 1'b0;
        n_w_clr      = 1'b0;
        o_cmd_pop    = 1'b0;
        rd_addr      = r_ra;
        unique case (r_state)
            BS_CLEAR: begin
                if (&r_clr_cnt) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (!i_cmd_empty) begin
                    unique case (i_cmd.kind)
                        CMD_LIT: begin
                            if (issue_ok) begin
                                o_cmd_pop    = 1'b1;
                                n_w_valid    = 1'b1;
                                n_w_lit      = 1'b1;
                                n_w_run_last = 1'b1;
                                n_w_clr      = i_cmd.last;
                            end
                        end
                        CMD_COPY: begin
                            if (issue_ok) begin
                                o_cmd_pop = 1'b1;
                                rd_addr   = cmd_pos;
                                n_ra      = cmd_pos + 1'b1;
                                n_left    = cmd_len - 1'b1;
                                n_cp_last = i_cmd.last;
                                n_w_valid = 1'b1;
                                n_state   = BS_COPY;
                            end
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                            n_w_clr   = i_cmd.last;
                        end
                    endcase
                end
            end
            BS_COPY: begin
                if (issue_ok) begin
                    rd_addr      = r_ra;
                    n_ra         = r_ra + 1'b1;
                    n_left       = r_left - 1'b1;
                    n_w_valid    = 1'b1;
                    n_w_run_last = (r_left == LEN_W'(1));
                    n_w_clr      = r_cp_last && (r_left == LEN_W'(1));
                    if (r_left == LEN_W'(1)) begin
                        n_state = BS_IDLE;
                    end
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    // Forward the byte written this cycle when the read hits the same entry
    assign n_fwd  = r_w_valid && (rd_addr == r_wp);
    assign w_data = r_w_lit ? r_w_lit_data : (r_fwd ? r_fwd_data : r_rd_data);

    assign mem_we    = o_clearing || r_w_valid;
    assign mem_waddr = o_clearing ? r_clr_cnt : r_wp;
    assign mem_wdata = o_clearing ? 8'h00 : w_data;

    assign o_out_push     = r_w_valid;
    assign o_out.out_byte = w_data;
    assign o_out.run_last = r_w_run_last;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_CLEAR;
            r_clr_cnt <= '0;
            r_wp      <= '0;
            r_w_valid <= 1'b0;
            r_w_clr   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_w_valid <= n_w_valid;
            r_w_clr   <= n_w_clr;
            if (o_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (r_w_clr) begin
                r_wp <= '0;
            end else if (r_w_valid) begin
                r_wp <= r_wp + 1'b1;
            end
        end
    end

    // Run and write stage payload
    always_ff @(posedge i_clk) begin
        r_ra         <= n_ra;
        r_left       <= n_left;
        r_cp_last    <= n_cp_last;
        r_w_lit      <= n_w_lit;
        r_w_lit_data <= n_w_lit_data;
        r_w_run_last <= n_w_run_last;
        r_fwd        <= n_fwd;
        r_fwd_data   <= w_data;
    end

    // Window write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_win[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_win[rd_addr];
    end

endmodule

// ===== src/lzss_window_decoder_top.sv =====
// LZSS window decoder: front parser, command queue, copy engine, output queue.
//
// Input channel: push/full. A word is one compressed byte plus stream_last.
// A word is taken at a clock edge with push high and full low.
// Output channel: empty/pop. The oldest decoded byte shows on o_data while
// empty is low and leaves at an edge with pop high. run_last marks the last
// byte caused by one input word.
// Flag bytes and reference low bytes produce nothing.
// A literal yields one byte; a reference yields 3 to 2**LENGTH_BITS+2 bytes
// read from the window, and the copy engine takes no new command meanwhile.
// A byte passes the command queue, write stage and output queue in turn.
// After reset the window is zero-filled, one entry a cycle, for
// all 2**WINDOW_BITS entries; full stays high during that pass.
// If the receiver stops popping, the output queue fills, the copy engine
// halts, the command queue fills and full rises; nothing is lost.
// stream_last rewinds the parser and the write pointer; the window is kept.
module lzss_window_decoder_top #(
    parameter int WINDOW_BITS = lwd_pkg::WINDOW_BITS_DEF,
    parameter int LENGTH_BITS = lwd_pkg::LENGTH_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  lwd_pkg::t_in  i_data,
    output logic          empty,
    input  logic          pop,
    output lwd_pkg::t_out o_data
);
    import lwd_pkg::*;

    localparam int CQ_CW = $clog2(CMDQ_DEPTH + 1);
    localparam int OQ_CW = $clog2(OUTQ_DEPTH + 1);

    logic             accept;
    logic             cmd_push;
    t_cmd             cmd_in;
    t_cmd             cmd_out;
    logic             cmd_full;
    logic             cmd_empty;
    logic             cmd_pop;
    logic [CQ_CW-1:0] cmd_count;
    logic             out_push;
    t_out             out_item;
    logic             out_full;
    logic [OQ_CW-1:0] out_count;
    logic             clearing;

    // Hold off input while the window clears or the command queue is full
    assign full   = cmd_full || clearing;
    assign accept = push && !full;

    lwd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data      (i_data),
        .o_cmd_valid (cmd_push),
        .o_cmd       (cmd_in)
    );

    lwd_fifo #(
        .t_item (t_cmd),
        .DEPTH  (CMDQ_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_item  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_item  (cmd_out),
        .o_empty (cmd_empty),
        .o_count (cmd_count)
    );

    lwd_back #(
        .WINDOW_BITS (WINDOW_BITS),
        .LENGTH_BITS (LENGTH_BITS),
        .OUT_DEPTH   (OUTQ_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_out_count (out_count),
        .o_out_push  (out_push),
        .o_out       (out_item),
        .o_clearing  (clearing)
    );

    lwd_fifo #(
        .t_item (t_out),
        .DEPTH  (OUTQ_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_item  (out_item),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_item  (o_data),
        .o_empty (empty),
        .o_count (out_count)
    );

    // The copy engine's credit check must never overrun the output queue
    a_out_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_push |-> !out_full)
        else $error("output queue overrun");

    // The front end only pushes when the command queue has room
    a_cmd_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push && accept |-> !cmd_full)
        else $error("command queue overrun");

    // No decoded byte leaves and no command is taken while the window clears
    a_no_emit_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !out_push && !cmd_pop)
        else $error("engine active during window clear");

    // Command queue occupancy never exceeds its depth
    a_cmd_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_count <= CQ_CW'(CMDQ_DEPTH))
        else $error("command queue count out of range");

endmodule
